// ----- rtl/pf_pkg.sv -----
// pf_pkg: widths, derived constants and controller states for the prime factorizer
// no dependencies; used by prime_factorizer.sv
package pf_pkg;

	// width of the value to factor and of each factor
	localparam int VALUE_BITS = 31;
	// stream data width, value packed from bit 0 and zero filled to whole bytes
	localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
	// width of floor(sqrt(value))
	localparam int ROOT_BITS = (VALUE_BITS + 1) / 2;
	// trial divisor runs up to root + 1
	localparam int DIV_BITS = ROOT_BITS + 1;
	// bit counter for the serial divide and square root
	localparam int CNT_BITS = $clog2(VALUE_BITS);
	// first trial divisor
	localparam int FIRST_DIVISOR = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT,
		ST_CHECK,
		ST_DIV,
		ST_FOUND,
		ST_FLUSH
	} state_t;

endpackage

// ----- rtl/prime_factorizer.sv -----
// prime_factorizer: trial division factorization with a bit serial divider and square root
// depends on pf_pkg for widths and the controller state type
//
// Usage:
//  s_* channel takes one value (s_tdata bits 30:0) per transfer; the block accepts a
//  new value only when the previous one has been fully factored and its last result
//  has been loaded into the output register.
//  m_* channel returns the prime factors in ascending order with repeats, one per
//  transfer; m_tlast marks the final factor of a value. Values 0 and 1 give a single
//  transfer with factor 0, m_tuser (none) and m_tlast set.
//  Search: a two-bit-per-cycle square root gives the divisor bound, then each trial
//  divisor costs one bound check plus a restoring divide, one quotient bit per
//  cycle, and each factor found adds a step in ST_FOUND. A large prime needs about
//  46340 trials.
//  Throughput: one value at a time.
//  Reset: arst_n clears the controller and the output valid; the block comes up idle.
//  Stall: the output is a single register; while m_tready is low and a result is waiting,
//  the search pauses at the next factor found or the flush until the transfer completes.
module prime_factorizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pf_pkg::TDATA_BITS-1:0]   s_tdata,   // [30:0] value, rest zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pf_pkg::TDATA_BITS-1:0]   m_tdata,   // [30:0] factor, rest zero
	output logic                            m_tlast,
	output logic                            m_tuser    // [0] none
);

	localparam int VB = pf_pkg::VALUE_BITS;
	localparam int RB = pf_pkg::ROOT_BITS;
	localparam int DB = pf_pkg::DIV_BITS;
	localparam int CB = pf_pkg::CNT_BITS;

	pf_pkg::state_t state_q, state_d;

	logic [VB-1:0]   rem_q, rem_d;
	logic [VB-1:0]   dvd_q, dvd_d;
	logic [DB-1:0]   part_q, part_d;
	logic [DB-1:0]   div_q, div_d;
	logic [RB-1:0]   root_q, root_d;
	logic [2*RB-1:0] sq_val_q, sq_val_d;
	logic [RB:0]     sq_rem_q, sq_rem_d;
	logic [CB-1:0]   cnt_q, cnt_d;
	logic [VB-1:0]   held_q, held_d;
	logic            pending_q, pending_d;
	logic            m_tvalid_q, m_tvalid_d;
	logic [VB-1:0]   m_factor_q, m_factor_d;
	logic            m_last_q, m_last_d;
	logic            m_none_q, m_none_d;

	logic            out_free;
	logic            rem_gt1;
	logic [RB+2:0]   sq_shift;
	logic [RB+2:0]   sq_trial;
	logic            sq_ge;
	logic [DB:0]     dv_shift;
	logic            dv_ge;
	logic [DB:0]     dv_sub;
	logic [VB-1:0]   in_value;

	assign in_value = s_tdata[VB-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign rem_gt1  = |rem_q[VB-1:1];

	// square root digit step: two value bits per cycle
	assign sq_shift = {sq_rem_q, sq_val_q[2*RB-1 -: 2]};
	assign sq_trial = (RB+3)'({root_q, 2'b01});
	assign sq_ge    = sq_shift >= sq_trial;

	// restoring divide step: one quotient bit per cycle
	assign dv_shift = {part_q, dvd_q[VB-1]};
	assign dv_ge    = dv_shift >= (DB+1)'(div_q);
	assign dv_sub   = dv_shift - (DB+1)'(div_q);

	// next state and datapath control
	always_comb begin
		state_d    = state_q;
		rem_d      = rem_q;
		dvd_d      = dvd_q;
		part_d     = part_q;
		div_d      = div_q;
		root_d     = root_q;
		sq_val_d   = sq_val_q;
		sq_rem_d   = sq_rem_q;
		cnt_d      = cnt_q;
		held_d     = held_q;
		pending_d  = pending_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		m_factor_d = m_factor_q;
		m_last_d   = m_last_q;
		m_none_d   = m_none_q;
		s_tready   = 1'b0;

		unique case (state_q)
			pf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					rem_d     = in_value;
					held_d    = '0;
					pending_d = 1'b0;
					div_d     = DB'(pf_pkg::FIRST_DIVISOR);
					cnt_d     = '0;
					sq_val_d  = (2*RB)'(in_value);
					sq_rem_d  = '0;
					root_d    = '0;
					state_d   = (|in_value[VB-1:1]) ? pf_pkg::ST_ROOT : pf_pkg::ST_FLUSH;
				end
			end
			pf_pkg::ST_ROOT: begin
				sq_val_d = {sq_val_q[2*RB-3:0], 2'b00};
				if (sq_ge) begin
					sq_rem_d = (RB+1)'(sq_shift - sq_trial);
					root_d   = {root_q[RB-2:0], 1'b1};
				end else begin
					sq_rem_d = (RB+1)'(sq_shift);
					root_d   = {root_q[RB-2:0], 1'b0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CB'(RB - 1)) begin
					cnt_d   = '0;
					state_d = pf_pkg::ST_CHECK;
				end
			end
			pf_pkg::ST_CHECK: begin
				if (rem_gt1 && (div_q <= DB'(root_q))) begin
					dvd_d   = rem_q;
					part_d  = '0;
					cnt_d   = '0;
					state_d = pf_pkg::ST_DIV;
				end else begin
					state_d = pf_pkg::ST_FLUSH;
				end
			end
			pf_pkg::ST_DIV: begin
				part_d = dv_ge ? DB'(dv_sub) : DB'(dv_shift);
				dvd_d  = {dvd_q[VB-2:0], dv_ge};
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CB'(VB - 1)) begin
					cnt_d = '0;
					if (part_d == '0) begin
						state_d = pf_pkg::ST_FOUND;
					end else begin
						div_d   = div_q + 1'b1;
						state_d = pf_pkg::ST_CHECK;
					end
				end
			end
			pf_pkg::ST_FOUND: begin
				// hold the new factor back; release the previous one as not last
				if (!pending_q || out_free) begin
					if (pending_q) begin
						m_tvalid_d = 1'b1;
						m_factor_d = held_q;
						m_last_d   = 1'b0;
						m_none_d   = 1'b0;
					end
					held_d    = VB'(div_q);
					pending_d = 1'b1;
					rem_d     = dvd_q;
					state_d   = pf_pkg::ST_CHECK;
				end
			end
			pf_pkg::ST_FLUSH: begin
				if (rem_gt1) begin
					// leftover remainder is the largest prime factor
					if (!pending_q || out_free) begin
						if (pending_q) begin
							m_tvalid_d = 1'b1;
							m_factor_d = held_q;
							m_last_d   = 1'b0;
							m_none_d   = 1'b0;
						end
						held_d    = rem_q;
						pending_d = 1'b1;
						rem_d     = VB'(1);
					end
				end else if (out_free) begin
					m_tvalid_d = 1'b1;
					m_factor_d = held_q;
					m_last_d   = 1'b1;
					m_none_d   = !pending_q;
					state_d    = pf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pf_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pf_pkg::ST_IDLE;
			pending_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pending_q  <= pending_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rem_q      <= rem_d;
		dvd_q      <= dvd_d;
		part_q     <= part_d;
		div_q      <= div_d;
		root_q     <= root_d;
		sq_val_q   <= sq_val_d;
		sq_rem_q   <= sq_rem_d;
		cnt_q      <= cnt_d;
		held_q     <= held_d;
		m_factor_q <= m_factor_d;
		m_last_q   <= m_last_d;
		m_none_q   <= m_none_d;
	end

	// output transfer register
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = pf_pkg::TDATA_BITS'(m_factor_q);
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_none_q;

endmodule
